// ----- hw/rtl/banked_priority_message_queue_core_assert.svh -----
// Assertion macros shared by the queue RTL.
// Expects clk and rst in the scope of each use.
`ifndef BANKED_PRIORITY_MESSAGE_QUEUE_CORE_ASSERT_SVH
`define BANKED_PRIORITY_MESSAGE_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define BPMQ_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpmq assertion failed");

// next-cycle implication
`define BPMQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpmq assertion failed");

`endif

// ----- hw/rtl/bpmq_pkg.sv -----
// Shared types and codes for the banked priority message queue.
// No dependencies.
package bpmq_pkg;

  localparam logic [1:0] FUNC_ENQ = 2'd0;
  localparam logic [1:0] FUNC_DEQ = 2'd1;
  localparam logic [1:0] FUNC_CLR = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_NOMSG   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_SCAN,
    S_DQ_HEAD,
    S_DQ_MOVE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  prio;
    logic [31:0] payload;
    logic [4:0]  queue_len;
  } result_t;

endpackage

// ----- hw/rtl/bpmq_store.sv -----
// Message store RAM: one write port, one registered read port.
// No dependencies.
module bpmq_store #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 40,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/bpmq_ctrl.sv -----
// Sequencer, queue counts and shared priority compare for the queue bank.
// Depends on bpmq_pkg and banked_priority_message_queue_core_assert.svh.
`include "banked_priority_message_queue_core_assert.svh"

module bpmq_ctrl #(
  parameter int NUM_QUEUES   = 8,
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 32,
  parameter int AW           = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [1:0]                func,
  input  logic [3:0]                dest,
  input  logic [7:0]                prio_in,
  input  logic [PAYLOAD_BITS-1:0]   body_in,
  output logic                      idle,
  output logic                      res_valid,
  output bpmq_pkg::result_t         res,
  input  logic                      res_take,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic [PAYLOAD_BITS+7:0]   mem_wdata,
  output logic [AW-1:0]             mem_raddr,
  input  logic [PAYLOAD_BITS+7:0]   mem_rdata
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [AW-1:0] DEPTH_A = AW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  bpmq_pkg::state_t state, state_next;

  logic [CW-1:0]           counts [NUM_QUEUES];
  logic [QW-1:0]           q_sel;
  logic [AW-1:0]           base, base_next;
  logic [CW-1:0]           pos, pos_next;
  logic [CW-1:0]           cnt, cnt_next;
  logic [7:0]              prio, prio_next;
  logic [PAYLOAD_BITS-1:0] body, body_next;
  bpmq_pkg::result_t       res_next;

  logic                    dest_ok;
  logic [CW-1:0]           cur_cnt;
  logic [AW-1:0]           base_in;
  logic [7:0]              rd_prio;
  logic                    less;
  logic                    cnt_we;
  logic [CW-1:0]           cnt_wdata;

  assign dest_ok = (dest != 4'd0) && (dest <= 4'(NUM_QUEUES));
  assign q_sel   = QW'(dest - 4'd1);
  assign cur_cnt = counts[q_sel];
  assign base_in = AW'(q_sel) * DEPTH_A;
  assign rd_prio = mem_rdata[PAYLOAD_BITS+7:PAYLOAD_BITS];
  assign less    = rd_prio < prio;

  assign idle      = (state == bpmq_pkg::S_IDLE);
  assign res_valid = (state == bpmq_pkg::S_DONE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bpmq_pkg::S_IDLE: begin
        if (start) begin
          state_next = bpmq_pkg::S_DONE;
          if (dest_ok && func == bpmq_pkg::FUNC_ENQ && cur_cnt < DEPTH_C &&
              cur_cnt != '0) begin
            state_next = bpmq_pkg::S_ENQ_SCAN;
          end
          if (dest_ok && func == bpmq_pkg::FUNC_DEQ && cur_cnt != '0) begin
            state_next = bpmq_pkg::S_DQ_HEAD;
          end
        end
      end
      bpmq_pkg::S_ENQ_SCAN: begin
        if (pos == '0 || !less) begin
          state_next = bpmq_pkg::S_DONE;
        end
      end
      bpmq_pkg::S_DQ_HEAD: begin
        state_next = (cnt == CW'(1)) ? bpmq_pkg::S_DONE : bpmq_pkg::S_DQ_MOVE;
      end
      bpmq_pkg::S_DQ_MOVE: begin
        if (pos == cnt - CW'(1)) begin
          state_next = bpmq_pkg::S_DONE;
        end
      end
      bpmq_pkg::S_DONE: begin
        if (res_take) begin
          state_next = bpmq_pkg::S_IDLE;
        end
      end
      default: state_next = bpmq_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = base + AW'(pos);
    mem_wdata  = {prio, body};
    mem_raddr  = base;
    pos_next   = pos;
    cnt_next   = cnt;
    base_next  = base;
    prio_next  = prio;
    body_next  = body;
    res_next   = res;
    cnt_we     = 1'b0;
    cnt_wdata  = cur_cnt;
    case (state)
      bpmq_pkg::S_IDLE: begin
        if (start) begin
          base_next = base_in;
          prio_next = prio_in;
          body_next = body_in;
          cnt_next  = cur_cnt;
          res_next  = '{status: bpmq_pkg::STATUS_OK, prio: 8'd0, payload: 32'd0,
                        queue_len: 5'(cur_cnt)};
          if (!dest_ok) begin
            res_next.status    = bpmq_pkg::STATUS_INVALID;
            res_next.queue_len = 5'd0;
          end else begin
            case (func)
              bpmq_pkg::FUNC_ENQ: begin
                if (cur_cnt >= DEPTH_C) begin
                  res_next.status = bpmq_pkg::STATUS_FULL;
                end else begin
                  cnt_we             = 1'b1;
                  cnt_wdata          = cur_cnt + CW'(1);
                  res_next.queue_len = 5'(cur_cnt + CW'(1));
                  pos_next           = cur_cnt;
                  mem_raddr          = base_in + AW'(cur_cnt) - AW'(1);
                  if (cur_cnt == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = base_in;
                    mem_wdata = {prio_in, body_in};
                  end
                end
              end
              bpmq_pkg::FUNC_DEQ: begin
                if (cur_cnt == '0) begin
                  res_next.status = bpmq_pkg::STATUS_NOMSG;
                end else begin
                  cnt_we             = 1'b1;
                  cnt_wdata          = cur_cnt - CW'(1);
                  res_next.queue_len = 5'(cur_cnt - CW'(1));
                  mem_raddr          = base_in;
                end
              end
              bpmq_pkg::FUNC_CLR: begin
                cnt_we             = 1'b1;
                cnt_wdata          = '0;
                res_next.queue_len = 5'd0;
              end
              default: begin
                res_next.queue_len = 5'(cur_cnt);
              end
            endcase
          end
        end
      end
      bpmq_pkg::S_ENQ_SCAN: begin
        mem_we = 1'b1;
        if (pos != '0 && less) begin
          mem_wdata = mem_rdata;
          pos_next  = pos - CW'(1);
          mem_raddr = base + AW'(pos) - AW'(2);
        end
      end
      bpmq_pkg::S_DQ_HEAD: begin
        res_next.prio    = rd_prio;
        res_next.payload = 32'(mem_rdata[PAYLOAD_BITS-1:0]);
        pos_next         = CW'(1);
        mem_raddr        = base + AW'(1);
      end
      bpmq_pkg::S_DQ_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = base + AW'(pos) - AW'(1);
        mem_wdata = mem_rdata;
        pos_next  = pos + CW'(1);
        mem_raddr = base + AW'(pos) + AW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpmq_pkg::S_IDLE;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        counts[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cnt_we) begin
        counts[q_sel] <= cnt_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    base <= base_next;
    pos  <= pos_next;
    cnt  <= cnt_next;
    prio <= prio_next;
    body <= body_next;
    res  <= res_next;
  end

  `BPMQ_ASSERT(a_scan_pos, state == bpmq_pkg::S_ENQ_SCAN, pos < DEPTH_C)
  `BPMQ_ASSERT(a_move_idx, state == bpmq_pkg::S_DQ_MOVE, (pos != '0) && (pos < cnt))
  `BPMQ_ASSERT(a_done_quiet, state == bpmq_pkg::S_DONE, !mem_we && !cnt_we)
  `BPMQ_ASSERT(a_count_cap, state == bpmq_pkg::S_IDLE, cur_cnt <= DEPTH_C)
  `BPMQ_ASSERT_NEXT(a_start_busy, start, !idle)

endmodule

// ----- hw/rtl/banked_priority_message_queue_core.sv -----
// Banked priority message queue: one bank of the message RAM per queue.
// Enqueue shifts one lower-priority entry per cycle; dequeue moves one entry per cycle.
// A new word is taken only while idle, so each shift or move completes before the next word.
// An output register holds the last result so the next word can be taken meanwhile.
// Reset clears queue counts and control; the message RAM is not cleared.
// Depends on bpmq_pkg, bpmq_store and bpmq_ctrl.
module banked_priority_message_queue_core #(
  parameter int NUM_QUEUES   = 8,
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [3:0]  dest,
  input  logic [7:0]  priority_req,
  input  logic [31:0] payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  out_priority,
  output logic [31:0] out_payload,
  output logic [4:0]  queue_len
);

  localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW      = $clog2(ENTRIES);
  localparam int EW      = PAYLOAD_BITS + 8;

  logic              start;
  logic              idle;
  logic              res_valid;
  logic              res_take;
  bpmq_pkg::result_t res;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [EW-1:0]     mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [EW-1:0]     mem_rdata;

  assign in_ready = idle;
  assign start    = in_valid && idle;
  assign res_take = !out_valid || out_ready;

  bpmq_ctrl #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .AW          (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .func     (func),
    .dest     (dest),
    .prio_in  (priority_req),
    .body_in  (PAYLOAD_BITS'(payload)),
    .idle     (idle),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  bpmq_store #(
    .DEPTH(ENTRIES),
    .WIDTH(EW),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      status       <= res.status;
      out_priority <= res.prio;
      out_payload  <= res.payload;
      queue_len    <= res.queue_len;
    end
  end

endmodule
